// ----- hw/rtl/olt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg
// shared widths, codes and types of the ordered list table engine
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W  = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
  localparam logic [OP_W-1:0] OP_GET        = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_LAST  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // what a scan token looks for as it walks the chain
  typedef enum logic [1:0] {
    SM_GET,
    SM_FIRST,
    SM_LAST
  } scan_mode_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } upd_t;

  // control part of the scan token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

endpackage

// ----- hw/rtl/olt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_in_if
// request channel: operation, position and value words
// ----------------------------------------------------------------------------
interface olt_in_if;
  logic                                valid;
  logic                                ready;
  logic        [olt_pkg::OP_W-1:0]     operation;
  logic        [olt_pkg::POS_W-1:0]    position;
  logic signed [olt_pkg::VAL_W-1:0]    value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

// ----- hw/rtl/olt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_out_if
// result channel: status, read value, found position and entry count words
// ----------------------------------------------------------------------------
interface olt_out_if;
  logic                                valid;
  logic                                ready;
  logic        [olt_pkg::ST_W-1:0]     status;
  logic signed [olt_pkg::VAL_W-1:0]    read_value;
  logic        [olt_pkg::POS_W-1:0]    found_position;
  logic        [olt_pkg::POS_W-1:0]    entry_count;

  modport source (output valid, output status, output read_value,
                  output found_position, output entry_count, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input entry_count, output ready);
endinterface

// ----- hw/rtl/ordered_list_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// ordered list of signed 32-bit entries kept in a chain of slot cells
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        word
//   in_chan   in    valid / ready    operation, position, value
//   out_chan  out   valid / ready    status, read_value, found_position,
//                                    entry_count
//
// insert, remove, rejected requests and unknown operations finish in the
// cycle they are taken; the result word sits in the output register next
// cycle. get, find-first and find-last send a token down the whole chain,
// one cell per cycle, through the start register and then the token register
// of each cell, so the chain length sets how long their result takes.
// reset (rst_n, synchronous) empties the list; the slot contents need none.
// in_ready is low while a scan runs and while a result word is stalled.
// ----------------------------------------------------------------------------
module ordered_list_table_engine #(
  parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  olt_in_if.sink    in_chan,
  olt_out_if.source out_chan
);
  import olt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // control
  state_t             state_r, state_nxt;
  logic               start_r, start_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // scan setup, held for the length of a scan
  scan_mode_t         scan_mode_r, scan_mode_nxt;
  logic [PW-1:0]      scan_idx_r, scan_idx_nxt;
  logic signed [VAL_W-1:0] scan_val_r, scan_val_nxt;

  // result word register
  logic [ST_W-1:0]         status_r, status_nxt;
  logic signed [VAL_W-1:0] rd_r, rd_nxt;
  logic [POS_W-1:0]        fpos_r, fpos_nxt;
  logic [POS_W-1:0]        cnt_r, cnt_nxt;

  // request decode
  logic          in_ready_w;
  logic          acc;
  logic [PW-1:0] pos_e;
  logic [PW-1:0] cnt_e;
  logic [PW-1:0] pos_m1;
  logic          pos_nz;
  logic          ins_legal;
  logic          rg_legal;
  logic          full;
  upd_t          upd;

  // chain wiring
  logic signed [VAL_W-1:0] entry_w    [CAPACITY];
  tok_t                    tok_w      [CAPACITY+1];
  logic [CW-1:0]           tok_pos_w  [CAPACITY+1];
  logic signed [VAL_W-1:0] tok_data_w [CAPACITY+1];

  assign in_ready_w    = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = in_ready_w;
  assign acc           = in_chan.valid && in_ready_w;

  assign pos_e     = PW'(in_chan.position);
  assign cnt_e     = PW'(count_r);
  assign pos_m1    = pos_e - PW'(1);
  assign pos_nz    = (in_chan.position != '0);
  // insert may land just past the last entry, remove and get may not
  assign ins_legal = pos_nz && (pos_m1 <= cnt_e);
  assign rg_legal  = pos_nz && (pos_e <= cnt_e);
  assign full      = (count_r == CAP_C);

  // token enters the head cell in the cycle after the request is taken, once the
  // scan setup registers hold it
  assign tok_w[0].valid = start_r;
  assign tok_w[0].hit   = 1'b0;
  assign tok_pos_w[0]   = '0;
  assign tok_data_w[0]  = '0;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    scan_mode_nxt = scan_mode_r;
    scan_idx_nxt  = scan_idx_r;
    scan_val_nxt  = scan_val_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    fpos_nxt      = fpos_r;
    cnt_nxt       = cnt_r;
    upd           = '0;

    if (acc) begin
      // immediate result fields; a scan overrides out_valid below
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      rd_nxt        = '0;
      fpos_nxt      = '0;
      cnt_nxt       = POS_W'(count_r);
      case (in_chan.operation)
        OP_INSERT: begin
          if (!ins_legal) begin
            status_nxt = ST_BAD_POS;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            upd.ins   = 1'b1;
            count_nxt = count_r + CW'(1);
            cnt_nxt   = POS_W'(count_r + CW'(1));
          end
        end
        OP_REMOVE: begin
          if (!rg_legal) begin
            status_nxt = ST_BAD_POS;
          end else begin
            upd.rem   = 1'b1;
            count_nxt = count_r - CW'(1);
            cnt_nxt   = POS_W'(count_r - CW'(1));
          end
        end
        OP_GET: begin
          if (!rg_legal) begin
            status_nxt = ST_BAD_POS;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            start_nxt     = 1'b1;
            scan_mode_nxt = SM_GET;
            scan_idx_nxt  = pos_m1;
          end
        end
        OP_FIND_FIRST, OP_FIND_LAST: begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_SCAN;
          start_nxt     = 1'b1;
          scan_mode_nxt = (in_chan.operation == OP_FIND_LAST) ? SM_LAST : SM_FIRST;
          scan_val_nxt  = in_chan.value;
        end
        default: begin
          // unknown operation: list untouched, count reported
        end
      endcase
    end

    // token leaves the tail cell: the scan is done
    if (tok_w[CAPACITY].valid) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      cnt_nxt       = POS_W'(count_r);
      if (tok_w[CAPACITY].hit) begin
        status_nxt = ST_OK;
        rd_nxt     = tok_data_w[CAPACITY];
        fpos_nxt   = (scan_mode_r == SM_GET) ? '0 : POS_W'(tok_pos_w[CAPACITY]);
      end else begin
        status_nxt = ST_NOT_FOUND;
        rd_nxt     = '0;
        fpos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    scan_mode_r <= scan_mode_nxt;
    scan_idx_r  <= scan_idx_nxt;
    scan_val_r  <= scan_val_nxt;
    status_r    <= status_nxt;
    rd_r        <= rd_nxt;
    fpos_r      <= fpos_nxt;
    cnt_r       <= cnt_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.read_value     = rd_r;
  assign out_chan.found_position = fpos_r;
  assign out_chan.entry_count    = cnt_r;

  // chain of slot cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;

    olt_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .upd          (upd),
      .upd_idx      (pos_m1),
      .upd_val      (in_chan.value),
      .prev_entry   (entry_w[PREV]),
      .next_entry   (entry_w[NEXT]),
      .count        (count_r),
      .scan_mode    (scan_mode_r),
      .scan_idx     (scan_idx_r),
      .scan_val     (scan_val_r),
      .tok_in       (tok_w[i]),
      .tok_in_pos   (tok_pos_w[i]),
      .tok_in_data  (tok_data_w[i]),
      .entry        (entry_w[i]),
      .tok_out      (tok_w[i+1]),
      .tok_out_pos  (tok_pos_w[i+1]),
      .tok_out_data (tok_data_w[i+1])
    );
  end

  // checks

  // a token only leaves the chain while a scan is running
  a_tok_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[CAPACITY].valid |-> (state_r == S_SCAN))
    else $error("scan token left the chain outside a scan");

  // the result register is free when a scan ends
  a_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[CAPACITY].valid |-> !out_valid_r)
    else $error("scan finished over a pending result word");

  // a get is only scanned for a legal position, so it must hit
  a_get_hits : assert property (@(posedge clk) disable iff (!rst_n)
    (tok_w[CAPACITY].valid && scan_mode_r == SM_GET) |-> tok_w[CAPACITY].hit)
    else $error("get scan found no entry");

  // the list never holds more than its capacity
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count beyond capacity");

  // no request taken while the chain is being scanned
  a_no_acc_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || start_r) |-> !in_ready_w)
    else $error("request taken during a scan");

endmodule

// ----- hw/rtl/olt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_cell
// one list slot: holds an entry, shifts with its neighbors, and checks the
// passing scan token against its entry
// ----------------------------------------------------------------------------
module olt_cell #(
  parameter int  CAPACITY = olt_pkg::CAPACITY_DEF,
  parameter int  IDX      = 0,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int PW       = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  olt_pkg::upd_t                     upd,
  input  logic        [PW-1:0]              upd_idx,
  input  logic signed [olt_pkg::VAL_W-1:0]  upd_val,
  input  logic signed [olt_pkg::VAL_W-1:0]  prev_entry,
  input  logic signed [olt_pkg::VAL_W-1:0]  next_entry,
  input  logic        [CW-1:0]              count,
  input  olt_pkg::scan_mode_t               scan_mode,
  input  logic        [PW-1:0]              scan_idx,
  input  logic signed [olt_pkg::VAL_W-1:0]  scan_val,
  input  olt_pkg::tok_t                     tok_in,
  input  logic        [CW-1:0]              tok_in_pos,
  input  logic signed [olt_pkg::VAL_W-1:0]  tok_in_data,
  output logic signed [olt_pkg::VAL_W-1:0]  entry,
  output olt_pkg::tok_t                     tok_out,
  output logic        [CW-1:0]              tok_out_pos,
  output logic signed [olt_pkg::VAL_W-1:0]  tok_out_data
);
  import olt_pkg::*;

  localparam logic [PW-1:0] IDX_P  = PW'(IDX);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_C1 = CW'(IDX + 1);

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  tok_t                    tok_r, tok_nxt;
  logic [CW-1:0]           tok_pos_r, tok_pos_nxt;
  logic signed [VAL_W-1:0] tok_data_r, tok_data_nxt;
  logic                    occupied;
  logic                    match;
  logic                    take;

  // shift up on insert, down on remove
  always_comb begin
    entry_nxt = entry_r;
    if (upd.ins) begin
      if (IDX_P == upd_idx) begin
        entry_nxt = upd_val;
      end else if (IDX_P > upd_idx) begin
        entry_nxt = prev_entry;
      end
    end else if (upd.rem) begin
      if (IDX_P >= upd_idx) begin
        entry_nxt = next_entry;
      end
    end
  end

  assign occupied = (IDX_C < count);
  assign match    = occupied && ((scan_mode == SM_GET) ? (IDX_P == scan_idx)
                                                       : (entry_r == scan_val));
  // first hit sticks, except a find-last lets later hits win
  assign take     = tok_in.valid && match && (!tok_in.hit || scan_mode == SM_LAST);

  always_comb begin
    tok_nxt      = tok_in;
    tok_pos_nxt  = tok_in_pos;
    tok_data_nxt = tok_in_data;
    if (take) begin
      tok_nxt.hit  = 1'b1;
      tok_pos_nxt  = IDX_C1;
      tok_data_nxt = (scan_mode == SM_GET) ? entry_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    tok_pos_r  <= tok_pos_nxt;
    tok_data_r <= tok_data_nxt;
  end

  assign entry        = entry_r;
  assign tok_out      = tok_r;
  assign tok_out_pos  = tok_pos_r;
  assign tok_out_data = tok_data_r;

endmodule
